@@ rtl/tsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsfd_pkg: shared types and constants for the Taylor-series float divider
// Holds the binary32 constants, opcode and request/response types used by every module.
// ----------------------------------------------------------------------------
package tsfd_pkg;

  localparam int unsigned MAX_TERMS = 63;

  localparam logic [31:0] F32_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] F32_INF  = 32'h7F80_0000;
  localparam logic [31:0] F32_SIGN = 32'h8000_0000;

  typedef enum logic [0:0] {
    OP_MUL = 1'b0,
    OP_ADD = 1'b1
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [31:0] x;
    logic [31:0] y;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] z;
  } fpu_rsp_t;

endpackage

@@ rtl/tsfd_fpu.sv @@
// ----------------------------------------------------------------------------
// tsfd_fpu: shared binary32 multiply/add unit
// Multi-cycle unit: operand decode, one product or aligned sum, then a
// normalize loop of one bit a cycle and a final round and pack.
// ----------------------------------------------------------------------------
module tsfd_fpu (
  input  logic               clk,
  input  logic               rst_n,
  input  tsfd_pkg::fpu_req_t req,
  output tsfd_pkg::fpu_rsp_t rsp
);
  import tsfd_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_OPER = 5'b00010,
    F_NORM = 5'b00100,
    F_PACK = 5'b01000,
    F_DONE = 5'b10000
  } fstate_t;

  fstate_t     st_r, st_nxt;
  fpu_op_t     op_r;
  logic [31:0] x_r, y_r, z_r, z_nxt;
  logic [63:0] sig_r, sig_nxt;
  logic signed [11:0] exp_r, exp_nxt;
  logic        sign_r, sign_nxt;

  logic        xnan, ynan, xinf, yinf, xzero, yzero;
  logic [23:0] xsig, ysig;
  logic signed [11:0] xexp, yexp;
  logic [30:0] mx, my;
  logic        x_big, sub;
  logic [31:0] big, sml;
  logic [63:0] sb, ss, ssh;
  logic [11:0] dd;
  logic        special;
  logic [31:0] special_z;

  // packing
  logic signed [11:0] extra;
  logic [6:0]  sh;
  logic [63:0] rem, half, q, mask;
  logic [31:0] ebits;
  logic [63:0] total;

  always_comb begin
    xnan  = (x_r[30:23] == 8'hFF) && (x_r[22:0] != 23'd0);
    ynan  = (y_r[30:23] == 8'hFF) && (y_r[22:0] != 23'd0);
    xinf  = x_r[30:0] == F32_INF[30:0];
    yinf  = y_r[30:0] == F32_INF[30:0];
    xzero = x_r[30:0] == 31'd0;
    yzero = y_r[30:0] == 31'd0;
    xsig  = (x_r[30:23] != 8'd0) ? {1'b1, x_r[22:0]} : {1'b0, x_r[22:0]};
    ysig  = (y_r[30:23] != 8'd0) ? {1'b1, y_r[22:0]} : {1'b0, y_r[22:0]};
    xexp  = (x_r[30:23] != 8'd0) ? $signed({4'd0, x_r[30:23]}) : 12'sd1;
    yexp  = (y_r[30:23] != 8'd0) ? $signed({4'd0, y_r[30:23]}) : 12'sd1;
    mx    = x_r[30:0];
    my    = y_r[30:0];
    x_big = mx >= my;
    big   = x_big ? x_r : y_r;
    sml   = x_big ? y_r : x_r;
    sub   = x_r[31] ^ y_r[31];
    sb    = (big[30:23] != 8'd0) ? {8'd0, 1'b1, big[22:0], 32'd0}
                                 : {8'd0, 1'b0, big[22:0], 32'd0};
    ss    = (sml[30:23] != 8'd0) ? {8'd0, 1'b1, sml[22:0], 32'd0}
                                 : {8'd0, 1'b0, sml[22:0], 32'd0};
    dd    = 12'((big[30:23] != 8'd0 ? {4'd0, big[30:23]} : 12'd1)
               - (sml[30:23] != 8'd0 ? {4'd0, sml[30:23]} : 12'd1));
    if (dd >= 12'd63) begin
      ssh = 64'd1;
    end else if (dd != 12'd0) begin
      mask = (64'd1 << dd[5:0]) - 64'd1;
      ssh  = (ss >> dd[5:0]) | {63'd0, (ss & mask) != 64'd0};
    end else begin
      ssh = ss;
    end
    mask = (64'd1 << dd[5:0]) - 64'd1;
    special   = 1'b1;
    special_z = 32'd0;
    if (op_r == OP_MUL) begin
      if (xnan || ynan || (xinf && yzero) || (yinf && xzero)) special_z = F32_QNAN;
      else if (xinf || yinf) special_z = ((x_r ^ y_r) & F32_SIGN) | F32_INF;
      else if (xzero || yzero) special_z = (x_r ^ y_r) & F32_SIGN;
      else special = 1'b0;
    end else begin
      if (xnan || ynan || (xinf && yinf && sub)) special_z = F32_QNAN;
      else if (xinf) special_z = x_r;
      else if (yinf) special_z = y_r;
      else if (xzero && yzero) special_z = x_r & y_r;
      else if (xzero) special_z = y_r;
      else if (yzero) special_z = x_r;
      else if (sub && mx == my) special_z = 32'd0;
      else special = 1'b0;
    end
  end

  always_comb begin
    extra = 12'sd1 - exp_r;
    if (exp_r < 12'sd1) begin
      sh    = (extra > 12'sd40) ? 7'd64 : 7'(32 + extra);
      ebits = 32'd0;
    end else begin
      sh    = 7'd32;
      ebits = 32'(exp_r - 12'sd1);
    end
    if (sh[6]) begin
      q = 64'd0; rem = 64'd0; half = 64'd0;
    end else begin
      rem  = sig_r & ((64'd1 << sh[5:0]) - 64'd1);
      half = 64'd1 << (sh[5:0] - 6'd1);
      q    = sig_r >> sh[5:0];
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    total = ({32'd0, ebits} << 23) + q;
  end

  always_comb begin
    st_nxt   = st_r;
    sig_nxt  = sig_r;
    exp_nxt  = exp_r;
    sign_nxt = sign_r;
    z_nxt    = z_r;
    unique case (st_r)
      F_IDLE: if (req.start) st_nxt = F_OPER;
      F_OPER: begin
        if (special) begin
          z_nxt  = special_z;
          st_nxt = F_DONE;
        end else if (op_r == OP_MUL) begin
          sign_nxt = x_r[31] ^ y_r[31];
          exp_nxt  = xexp + yexp - 12'sd118;
          sig_nxt  = {40'd0, xsig} * {40'd0, ysig};
          st_nxt   = F_NORM;
        end else begin
          sign_nxt = big[31];
          exp_nxt  = (big[30:23] != 8'd0) ? $signed({4'd0, big[30:23]}) : 12'sd1;
          sig_nxt  = sub ? sb - ssh : sb + ssh;
          st_nxt   = F_NORM;
        end
      end
      F_NORM: begin
        // step one bit a cycle toward the [2^55, 2^56) window
        if (sig_r < (64'd1 << 55)) begin
          sig_nxt = sig_r << 1;
          exp_nxt = exp_r - 12'sd1;
        end else if (sig_r >= (64'd1 << 56)) begin
          sig_nxt = (sig_r >> 1) | {63'd0, sig_r[0]};
          exp_nxt = exp_r + 12'sd1;
        end else begin
          st_nxt = F_PACK;
        end
      end
      F_PACK: begin
        z_nxt  = (total >= {32'd0, F32_INF}) ? ({sign_r, 31'd0} | F32_INF)
                                             : {sign_r, total[30:0]};
        st_nxt = F_DONE;
      end
      F_DONE: st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    sig_r  <= sig_nxt;
    exp_r  <= exp_nxt;
    sign_r <= sign_nxt;
    z_r    <= z_nxt;
    if (st_r == F_IDLE && req.start) begin
      op_r <= req.op;
      x_r  <= req.x;
      y_r  <= req.y;
    end
  end

  assign rsp.done = st_r == F_DONE;
  assign rsp.z    = z_r;

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |=> !rsp.done) else $error("fpu done held two cycles");
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_PACK) |-> (sig_r[63:56] == 8'd0 && sig_r[55]))
    else $error("fpu pack entered unnormalized");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_IDLE && req.start) |=> st_r == F_OPER)
    else $error("fpu start lost");

endmodule

@@ rtl/tsfd_seq.sv @@
// ----------------------------------------------------------------------------
// tsfd_seq: series sequencer
// Issues e = 1 - b*u, then sum += pw and pw *= e per term, then (a*u)*sum.
// ----------------------------------------------------------------------------
module tsfd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic [31:0]        u,
  input  logic [5:0]         n,
  output logic               busy,
  output logic               done,
  output logic [31:0]        q,
  output tsfd_pkg::fpu_req_t req,
  input  tsfd_pkg::fpu_rsp_t rsp
);
  import tsfd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_BU   = 8'b0000_0010,
    S_E    = 8'b0000_0100,
    S_AU   = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_PW   = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } sstate_t;

  sstate_t     st_r, st_nxt;
  logic        issue_r, issue_nxt;
  logic [31:0] a_r, b_r, u_r, e_r, au_r, sum_r, pw_r, q_r;
  logic [5:0]  cnt_r;

  always_comb begin
    st_nxt    = st_r;
    issue_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (start) begin st_nxt = S_BU; issue_nxt = 1'b1; end
      S_BU:   if (rsp.done) begin st_nxt = S_E;  issue_nxt = 1'b1; end
      S_E:    if (rsp.done) begin st_nxt = S_AU; issue_nxt = 1'b1; end
      S_AU: if (rsp.done) begin
        st_nxt = (cnt_r != 6'd0) ? S_SUM : S_FIN;
        issue_nxt = 1'b1;
      end
      S_SUM:  if (rsp.done) begin st_nxt = S_PW; issue_nxt = 1'b1; end
      S_PW: if (rsp.done) begin
        st_nxt = (cnt_r != 6'd1) ? S_SUM : S_FIN;
        issue_nxt = 1'b1;
      end
      S_FIN:  if (rsp.done) st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    req.start = issue_r;
    req.op    = OP_MUL;
    req.x     = b_r;
    req.y     = u_r;
    unique case (st_r)
      S_E:   begin req.op = OP_ADD; req.x = F32_ONE; req.y = e_r; end
      S_AU:  begin req.x = a_r; req.y = u_r; end
      S_SUM: begin req.op = OP_ADD; req.x = sum_r; req.y = pw_r; end
      S_PW:  begin req.x = pw_r; req.y = e_r; end
      S_FIN: begin req.x = au_r; req.y = sum_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      issue_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      issue_r <= issue_nxt;
    end
    if (st_r == S_IDLE && start) begin
      a_r   <= a;
      b_r   <= b;
      u_r   <= u;
      cnt_r <= (n > 6'(MAX_TERMS)) ? 6'(MAX_TERMS) : n;
      sum_r <= 32'd0;
      pw_r  <= F32_ONE;
    end
    if (rsp.done) begin
      unique case (st_r)
        S_BU:  e_r   <= rsp.z ^ F32_SIGN;
        S_E:   e_r   <= rsp.z;
        S_AU:  au_r  <= rsp.z;
        S_SUM: sum_r <= rsp.z;
        S_PW:  begin pw_r <= rsp.z; cnt_r <= cnt_r - 6'd1; end
        S_FIN: q_r   <= rsp.z;
        default: ;
      endcase
    end
  end

  assign busy = st_r != S_IDLE;
  assign done = st_r == S_OUT;
  assign q    = q_r;

  a_issue_gap: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |=> !issue_r) else $error("double issue");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("result strobe held");
  a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |-> !issue_r) else $error("issue in output state");

endmodule

@@ rtl/taylor_series_float_divider_unit.sv @@
// ----------------------------------------------------------------------------
// taylor_series_float_divider_unit: binary32 divide by Taylor series
// Top level: sequencer plus one shared multi-cycle float multiply/add unit.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_dividend, in_divisor, in_recip_seed and in_term_count and raise
//   start; the beat is taken at the edge where start is high and busy is low.
//   busy then stays high until the result is out.
//   The result beat sits on out_quotient for one cycle, marked by out_valid.
//   The receiver cannot stall; capture it in that cycle.
// Cost: every float operation runs through the shared unit, whose normalize
//   loop moves one bit a cycle: a multiply of normal operands takes 8 or 9
//   steps, an add without cancellation 0 or 1 step, deep cancellation or
//   subnormals up to about 55 steps. Special operands (zero, inf, NaN) skip
//   normalize. An item costs 3 + 2*n + 1 operations for n terms
//   (n saturates at 63).
// Reset: rst_n low synchronously returns the sequencer and the float unit to
//   idle; any item in flight is dropped and no result is given for it.
// ----------------------------------------------------------------------------
module taylor_series_float_divider_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_dividend,
  input  logic [31:0] in_divisor,
  input  logic [31:0] in_recip_seed,
  input  logic [5:0]  in_term_count,
  output logic        out_valid,
  output logic [31:0] out_quotient
);
  import tsfd_pkg::*;

  fpu_req_t req;
  fpu_rsp_t rsp;

  // sequencer: walks setup, series terms and final multiply
  tsfd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .a     (in_dividend),
    .b     (in_divisor),
    .u     (in_recip_seed),
    .n     (in_term_count),
    .busy  (busy),
    .done  (out_valid),
    .q     (out_quotient),
    .req   (req),
    .rsp   (rsp)
  );

  // shared float unit, one operation at a time
  tsfd_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Taylor-series binary32 divider
// Directed table of corner operands, then randomized seed/divisor pairs and
// raw bit noise, each checked bit for bit against its table value or a local series model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsfd_pkg::*;

  localparam int RAND_BEATS = 1050;
  localparam int DRAIN_LIMIT = 2_000_000;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] u;
    logic [5:0]  n;
    bit          typed;
    logic [31:0] q;
  } div_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_dividend;
  logic [31:0] in_divisor;
  logic [31:0] in_recip_seed;
  logic [5:0]  in_term_count;
  logic        out_valid;
  logic [31:0] out_quotient;

  logic [31:0] quotient_q[$];
  int          err_cnt;
  int          idle_pct;
  div_row_t    plan[$];

  taylor_series_float_divider_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_dividend   (in_dividend),
    .in_divisor    (in_divisor),
    .in_recip_seed (in_recip_seed),
    .in_term_count (in_term_count),
    .out_valid     (out_valid),
    .out_quotient  (out_quotient)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // binary32 arithmetic, round to nearest even, subnormals kept
  // --------------------------------------------------------------------------
  function automatic bit f32_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit f32_inf(logic [31:0] x);
    return x[30:0] == F32_INF[30:0];
  endfunction

  function automatic bit f32_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [63:0] f32_mant(logic [31:0] x);
    return {40'd0, (x[30:23] != 0), x[22:0]};
  endfunction

  function automatic int f32_bexp(logic [31:0] x);
    return (x[30:23] != 0) ? int'(x[30:23]) : 1;
  endfunction

  // Value is m * 2^(e - 127 - 55); m must be nonzero.
  function automatic logic [31:0] f32_round(logic s, int e, logic [63:0] m);
    logic [63:0] q, rem, half, tot, ebits;
    int sh;
    // Normalize so the leading one sits at bit 55, folding lost bits in sticky.
    while (m < (64'd1 << 55)) begin
      m = m << 1;
      e--;
    end
    while (m >= (64'd1 << 56)) begin
      m = (m >> 1) | (m & 64'd1);
      e++;
    end
    if (e < 1) begin
      sh = (1 - e > 40) ? 64 : 32 + (1 - e);
      ebits = 0;
    end else begin
      sh = 32;
      ebits = 64'(e - 1);
    end
    if (sh >= 64) begin
      q = 0;
    end else begin
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q    = m >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    // Carry out of the mantissa bumps the exponent for free; clamp at inf.
    tot = (ebits << 23) + q;
    if (tot >= 64'(F32_INF)) return {s, F32_INF[30:0]};
    return {s, tot[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] x, logic [31:0] y);
    logic s;
    s = x[31] ^ y[31];
    if (f32_nan(x) || f32_nan(y)) return F32_QNAN;
    if ((f32_inf(x) && f32_zero(y)) || (f32_inf(y) && f32_zero(x))) return F32_QNAN;
    if (f32_inf(x) || f32_inf(y)) return {s, F32_INF[30:0]};
    if (f32_zero(x) || f32_zero(y)) return {s, 31'd0};
    return f32_round(s, f32_bexp(x) + f32_bexp(y) - 118, f32_mant(x) * f32_mant(y));
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] x, logic [31:0] y);
    logic [31:0] hi, lo;
    logic [63:0] mh, ml, lost, acc;
    int d;
    if (f32_nan(x) || f32_nan(y)) return F32_QNAN;
    if (f32_inf(x) && f32_inf(y) && (x[31] != y[31])) return F32_QNAN;
    if (f32_inf(x)) return x;
    if (f32_inf(y)) return y;
    if (f32_zero(x) && f32_zero(y)) return x & y;
    if (f32_zero(x)) return y;
    if (f32_zero(y)) return x;
    if (x[30:0] >= y[30:0]) begin
      hi = x;
      lo = y;
    end else begin
      hi = y;
      lo = x;
    end
    // Exact cancellation gives +0.
    if (x[31] != y[31] && x[30:0] == y[30:0]) return 32'd0;
    mh = f32_mant(hi) << 32;
    ml = f32_mant(lo) << 32;
    d = f32_bexp(hi) - f32_bexp(lo);
    if (d >= 63) begin
      ml = 64'd1;
    end else if (d > 0) begin
      lost = ml & ((64'd1 << d) - 64'd1);
      ml = (ml >> d) | 64'(lost != 0);
    end
    acc = (x[31] != y[31]) ? mh - ml : mh + ml;
    return f32_round(hi[31], f32_bexp(hi), acc);
  endfunction

  // Series quotient: (a*u) * sum of e^k for k < n, e = 1 - b*u.
  function automatic logic [31:0] calc_quotient(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] u, logic [5:0] n);
    logic [31:0] e, acc, pw;
    int terms;
    terms = (n > MAX_TERMS) ? MAX_TERMS : int'(n);
    e   = f32_add(F32_ONE, f32_mul(b, u) ^ F32_SIGN);
    acc = 32'd0;
    pw  = F32_ONE;
    for (int k = 0; k < terms; k++) begin
      acc = f32_add(acc, pw);
      pw  = f32_mul(pw, e);
    end
    return f32_mul(f32_mul(a, u), acc);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: raise start with the operands and hold until the beat is
  // taken (start high, busy low at the edge). The expectation is queued at
  // that same edge so the checker always sees it before the result.
  // --------------------------------------------------------------------------
  task automatic issue(div_row_t r);
    start         <= 1'b1;
    in_dividend   <= r.a;
    in_divisor    <= r.b;
    in_recip_seed <= r.u;
    in_term_count <= r.n;
    do @(posedge clk); while (!(start && !busy));
    quotient_q.push_back(r.typed ? r.q : calc_quotient(r.a, r.b, r.u, r.n));
  endtask

  // Drop start for a random stretch; leave it up when no gap is drawn so the
  // next beat follows back to back with a single assignment to start.
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Well-formed job: seed close to 1/b so |e| stays small and the series
  // converges, with noise in the low seed bits; otherwise raw bit patterns.
  function automatic div_row_t rand_row();
    div_row_t r;
    logic [7:0] eb;
    logic [22:0] fb;
    int pick;
    r.typed = 1'b0;
    r.q = 32'd0;
    r.a = $urandom;
    pick = $urandom_range(99);
    if (pick < 80) r.n = 6'($urandom_range(0, 12));
    else if (pick < 95) r.n = 6'($urandom_range(13, 32));
    else r.n = 6'($urandom_range(33, 63));
    if ($urandom_range(99) < 70) begin
      eb = 8'($urandom_range(1, 252));
      fb = 23'($urandom);
      r.b = {1'($urandom), eb, fb};
      r.u = {r.b[31], 8'(253 - eb), ~fb};
      r.u[22:0] = r.u[22:0] ^ 23'($urandom_range(0, ($urandom_range(3) == 0) ? 8191 : 15));
      if ($urandom_range(3) == 0) r.a = {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
    end else begin
      r.b = $urandom;
      r.u = $urandom;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: the receiver cannot stall, so check every strobed beat
  // against the oldest pending expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (quotient_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_quotient);
        err_cnt++;
      end else begin
        if (out_quotient !== quotient_q[0]) begin
          $display("%0t: quotient mismatch, expected %h, actual %h",
                   $time, quotient_q[0], out_quotient);
          err_cnt++;
        end
        void'(quotient_q.pop_front());
      end
    end
  end

  // Watchdog: far beyond the slowest legal run (every job at 63 terms with
  // worst normalize cost on each operation).
  initial begin
    #400_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int waited;
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_dividend   = 32'd0;
    in_divisor    = 32'd0;
    in_recip_seed = 32'd0;
    in_term_count = 6'd0;
    err_cnt       = 0;
    idle_pct      = 35;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: a, b, u, n, typed, quotient (typed rows only).
    // Zero term count: signed zero, or NaN for an infinite/NaN a*u.
    plan.push_back('{32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 6'd0,  1, 32'h0000_0000});
    plan.push_back('{32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000, 6'd0,  1, 32'h8000_0000});
    plan.push_back('{32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000, 6'd0,  1, F32_QNAN});
    // NaN inputs come back as the canonical quiet NaN.
    plan.push_back('{32'h7FFF_FFFF, 32'h3F80_0000, 32'h3F80_0000, 6'd5,  1, F32_QNAN});
    plan.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1, F32_QNAN});
    plan.push_back('{32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000, 6'd1,  1, 32'h3F80_0000});
    // b*u exactly one: e cancels to +0, only the first term survives.
    plan.push_back('{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 6'd63, 1, 32'h3F80_0000});
    plan.push_back('{32'h4040_0000, 32'h4000_0000, 32'h3F00_0000, 6'd4,  1, 32'h3FC0_0000});
    plan.push_back('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 6'd63, 1, 32'h0000_0000});
    // Overflow of a*u to infinity, and the smallest subnormal passing through.
    plan.push_back('{32'h7F7F_FFFF, 32'h0000_0000, 32'h7F7F_FFFF, 6'd1,  1, F32_INF});
    plan.push_back('{32'h0000_0001, 32'h0000_0000, 32'h3F80_0000, 6'd1,  1, 32'h0000_0001});
    plan.push_back('{32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 6'd3,  1, 32'h0000_0000});
    // Remaining rows go through the predictor.
    plan.push_back('{32'h3F80_0000, 32'h4040_0000, 32'h3EAA_AAAB, 6'd10, 0, 32'h0});
    plan.push_back('{32'h40A0_0000, 32'hC0E0_0000, 32'hBE10_0000, 6'd20, 0, 32'h0});
    plan.push_back('{32'h8000_0000, 32'h3FC0_0000, 32'h3F2A_AAAB, 6'd7,  0, 32'h0});
    plan.push_back('{32'h3F80_0000, 32'h7F80_0000, 32'h0000_0000, 6'd3,  0, 32'h0});
    plan.push_back('{32'h3F80_0000, 32'h0000_0001, 32'h7F7F_FFFF, 6'd63, 0, 32'h0});
    plan.push_back('{32'h0080_0000, 32'h3F80_0000, 32'h3F00_0000, 6'd63, 0, 32'h0});
    plan.push_back('{32'h7F7F_FFFF, 32'h4000_0000, 32'h3F00_0001, 6'd33, 0, 32'h0});
    plan.push_back('{32'h007F_FFFF, 32'hBF80_0000, 32'h3F80_0000, 6'd2,  0, 32'h0});
    plan.push_back('{32'h3F80_0000, 32'h3F80_0000, 32'hFF80_0000, 6'd2,  0, 32'h0});

    foreach (plan[i]) begin
      issue(plan[i]);
      sender_gap();
    end

    // Random part in three stretches: 35% sender idling, then 73%, then none.
    for (int i = 0; i < RAND_BEATS; i++) begin
      if (i == RAND_BEATS / 3) idle_pct = 73;
      if (i == 2 * RAND_BEATS / 3) idle_pct = 0;
      issue(rand_row());
      sender_gap();
    end
    start <= 1'b0;

    // Drain, then allow a little extra time for any stray strobe.
    waited = 0;
    while (quotient_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);

    if (quotient_q.size() != 0) begin
      $display("%0t: %0d results never arrived, expected %h, actual none",
               $time, quotient_q.size(), quotient_q[0]);
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tsfd_pkg.sv
rtl/tsfd_fpu.sv
rtl/tsfd_seq.sv
rtl/taylor_series_float_divider_unit.sv
sim/tb_top.sv
